// File: sv/assert_macros.svh
// Assertion helpers for the RTL. Each expands to one labeled
// concurrent assertion clocked on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Check a property at every clock edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

// File: sv/msbp_pkg.sv
package msbp_pkg;

  localparam int unsigned MAX_WRITE_BITS = 64;
  localparam int unsigned CAP_W          = 21;
  localparam int unsigned NBITS_W        = 7;
  localparam int unsigned CNT_W          = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_FLUSH   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [NBITS_W-1:0]        nbits;
    logic [MAX_WRITE_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       overflow;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_EMIT,
    ST_STATUS
  } state_e;

  typedef struct packed {
    logic load;
    logic fill;
    logic emit;
    logic status;
  } dp_cmd_t;

  typedef struct packed {
    logic need_fill;
    logic plan_k_zero;
    logic k_zero;
    logic k_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: sv/msbp_ctrl.sv
module msbp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  msbp_pkg::dp_status_t status_i,
  output msbp_pkg::dp_cmd_t    cmd_o
);
  import msbp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.need_fill) begin
            state_d = ST_FILL;
          end else if (status_i.plan_k_zero) begin
            state_d = ST_STATUS;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        state_d    = status_i.k_zero ? ST_STATUS : ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.k_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_STATUS: begin
        if (status_i.out_free) begin
          cmd_o.status = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/msbp_datapath.sv
module msbp_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [msbp_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  msbp_pkg::in_item_t           in_item_i,
  input  msbp_pkg::dp_cmd_t            cmd_i,
  output msbp_pkg::dp_status_t         status_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output msbp_pkg::out_item_t          out_item_o
);
  import msbp_pkg::*;

  logic [CAP_W-1:0]          cap_q, cap_d;
  logic [CAP_W-1:0]          be_q, be_d;
  logic [7:0]                staging_q, staging_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      ovf_q, ovf_d;
  logic [MAX_WRITE_BITS-1:0] vbuf_q, vbuf_d;
  logic [NBITS_W-1:0]        rem_q, rem_d;
  logic [CNT_W-1:0]          k_q, k_d;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_q, out_d;

  // Plan for the item at the input.
  logic [NBITS_W-1:0]        nsat;
  logic                      is_write;
  logic [NBITS_W-1:0]        bit_sum;
  logic [CNT_W-1:0]          need_e;
  logic [CAP_W-1:0]          room;
  logic [CAP_W-1:0]          allow;
  logic                      short_room;
  logic [CNT_W-1:0]          plan_k;
  logic                      flush_emit;
  logic                      flush_ovf;
  logic [CNT_W-1:0]          load_k;
  logic [MAX_WRITE_BITS-1:0] aligned;

  // One packing step.
  logic [7:0]                base_byte;
  logic [CNT_W-1:0]          base_cnt;
  logic [CNT_W-1:0]          space;
  logic [CNT_W-1:0]          take;
  logic                      out_free;

  always_comb begin
    nsat = (in_item_i.nbits > NBITS_W'(MAX_WRITE_BITS)) ? NBITS_W'(MAX_WRITE_BITS)
                                                          : in_item_i.nbits;
    is_write   = (in_item_i.opcode == OP_WRITE) && (nsat != '0);
    bit_sum    = NBITS_W'(cnt_q) + nsat - NBITS_W'(1);
    need_e     = bit_sum[NBITS_W-1:3];
    room       = (cap_q > be_q) ? (cap_q - be_q) : '0;
    allow      = (room != '0) ? (room - CAP_W'(1)) : '0;
    short_room = allow < CAP_W'(need_e);
    plan_k     = short_room ? allow[CNT_W-1:0] : need_e;
    flush_emit = (in_item_i.opcode == OP_FLUSH) && (cnt_q != '0) && (room != '0);
    flush_ovf  = (in_item_i.opcode == OP_FLUSH) && (cnt_q != '0) && (room == '0);
    if (is_write) begin
      load_k = plan_k;
    end else if (flush_emit) begin
      load_k = CNT_W'(1);
    end else begin
      load_k = '0;
    end
    aligned = in_item_i.value << (NBITS_W'(MAX_WRITE_BITS) - nsat);
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    status_o.need_fill   = is_write && (cnt_q < CNT_W'(8));
    status_o.plan_k_zero = (load_k == '0);
    status_o.k_zero      = (k_q == '0);
    status_o.k_last      = (k_q == CNT_W'(1));
    status_o.out_free    = out_free;
  end

  // An emit starts a fresh byte; a fill tops up the current one.
  always_comb begin
    base_byte = cmd_i.emit ? 8'd0 : staging_q;
    base_cnt  = cmd_i.emit ? '0 : cnt_q;
    space     = CNT_W'(8) - base_cnt;
    take      = (rem_q < NBITS_W'(space)) ? rem_q[CNT_W-1:0] : space;
  end

  always_comb begin
    cap_d       = cfg_we_i ? cfg_wdata_i : cap_q;
    be_d        = be_q;
    staging_d   = staging_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    vbuf_d      = vbuf_q;
    rem_d       = rem_q;
    k_d         = k_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.load) begin
      if (in_item_i.opcode == OP_RESTART) begin
        staging_d = '0;
        cnt_d     = '0;
        be_d      = '0;
        ovf_d     = 1'b0;
      end else begin
        ovf_d = ovf_q || (is_write && short_room) || flush_ovf;
      end
      vbuf_d = is_write ? aligned : '0;
      rem_d  = is_write ? nsat : '0;
      k_d    = load_k;
    end

    if (cmd_i.fill || cmd_i.emit) begin
      staging_d = base_byte | (vbuf_q[MAX_WRITE_BITS-1 -: 8] >> base_cnt);
      cnt_d     = base_cnt + take;
      vbuf_d    = vbuf_q << take;
      rem_d     = rem_q - NBITS_W'(take);
    end

    if (cmd_i.emit) begin
      out_d.out_byte   = staging_q;
      out_d.byte_valid = 1'b1;
      out_d.overflow   = ovf_q;
      out_d.last       = (k_q == CNT_W'(1));
      out_valid_d      = 1'b1;
      be_d             = be_q + CAP_W'(1);
      k_d              = k_q - CNT_W'(1);
    end

    if (cmd_i.status) begin
      out_d.out_byte   = 8'd0;
      out_d.byte_valid = 1'b0;
      out_d.overflow   = ovf_q;
      out_d.last       = 1'b1;
      out_valid_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      be_q        <= '0;
      staging_q   <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      rem_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      be_q        <= be_d;
      staging_q   <= staging_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      rem_q       <= rem_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vbuf_q <= vbuf_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: sv/msb_first_bit_packer_unit.sv
// Each item is latched at acceptance; a write with a partial staging byte tops it up first,
// then the item emits K bytes (K = 0..8) or, when K is 0, one status result. The emit step
// pushes one byte per cycle while the output register is free, and the single output
// register is shared by emit and status results. Flush, restart and no-op items follow
// the same load and emit or status steps. Reset (rst_ni low, asynchronous) clears
// all packing state and sets the capacity register to 4096; no clearing pass is needed.
`include "assert_macros.svh"

module msb_first_bit_packer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [msbp_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  msbp_pkg::in_item_t         in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output msbp_pkg::out_item_t        out_item_o
);
  import msbp_pkg::*;

  // The controller sequences one item at a time:
  //   load   - latch the item; capacity check and the final overflow flag
  //            are settled here, so every result carries the same flag
  //   fill   - top up a partial staging byte from the left-aligned value
  //   emit   - push the full staging byte and refill it from the value,
  //            once per byte that fits in the remaining room
  //   status - push a single no-byte result when nothing was emitted
  // The datapath owns the packing state, the capacity register and the
  // output register, which lets the next item in while a result waits.
  dp_cmd_t    cmd;
  dp_status_t status;

  msbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  msbp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Never push into an output register that still holds an untaken item.
  `ASSERT_IMPLIES(a_push_free, cmd.emit || cmd.status, !out_valid_o || !out_stall_i,
                  "push while output busy")
  // Commands are exclusive: one step per cycle.
  `ASSERT_ALWAYS(a_cmd_onehot, $onehot0({cmd.load, cmd.fill, cmd.emit, cmd.status}),
                 "overlapping commands")
  // A status push always presents a final, byte-less result.
  `ASSERT_NEXT(a_status_last, cmd.status,
               out_valid_o && out_item_o.last && !out_item_o.byte_valid,
               "bad status result")

endmodule

// File: sim/msb_first_bit_packer_unit_test.sv
import msbp_pkg::*;

// Tracks the packed byte stream: mirrors the packer state, turns every accepted
// item into the results it must produce and checks each delivered result.
class stream_scoreboard;
  logic [CAP_W-1:0] capacity;
  logic [7:0]       stage;
  int unsigned      staged;
  logic [CAP_W-1:0] emitted;
  bit               ovf;
  out_item_t        batch[$];
  out_item_t        pending[$];
  int unsigned      errors;

  function new();
    capacity = CAP_RESET;
    errors   = 0;
    clear_stream();
  endfunction

  function void clear_stream();
    stage   = '0;
    staged  = 0;
    emitted = '0;
    ovf     = 1'b0;
  endfunction

  function logic [CAP_W-1:0] room();
    return (capacity > emitted) ? capacity - emitted : '0;
  endfunction

  function void emit_stage();
    out_item_t r;
    r = '0;
    r.out_byte   = stage;
    r.byte_valid = 1'b1;
    if (batch.size() < 8) batch.push_back(r);
    emitted = emitted + 1'b1;
    stage   = '0;
    staged  = 0;
  endfunction

  // Pack the low n bits of v, earliest bit first; a full stage goes out only
  // when more bits arrive and only with two bytes of room left.
  function void pack_bits(int unsigned n, logic [63:0] v);
    int unsigned rem;
    int unsigned take;
    logic [7:0]  chunk;
    if (n == 0) return;
    if (n > MAX_WRITE_BITS) n = MAX_WRITE_BITS;
    if (n < 64) v = v & ((64'd1 << n) - 64'd1);
    rem = n;
    while (rem > 0) begin
      if (staged == 8) begin
        if (room() < 2) begin
          ovf = 1'b1;
          return;
        end
        emit_stage();
      end
      take = 8 - staged;
      if (take > rem) take = rem;
      chunk  = 8'((v >> (rem - take)) & ((64'd1 << take) - 64'd1));
      stage  = stage | 8'(chunk << (8 - staged - take));
      staged = staged + take;
      rem    = rem - take;
    end
  endfunction

  function void note_item(in_item_t it);
    batch.delete();
    case (it.opcode)
      OP_WRITE: pack_bits(it.nbits, it.value);
      OP_FLUSH: begin
        if (staged != 0) begin
          if (room() < 1) ovf = 1'b1;
          else emit_stage();
        end
      end
      OP_RESTART: clear_stream();
      default: ;
    endcase
    if (batch.size() == 0) batch.push_back('0);
    foreach (batch[k]) begin
      batch[k].overflow = ovf;
      batch[k].last     = (k == batch.size() - 1);
      pending.push_back(batch[k]);
    end
  endfunction

  function void check_byte(out_item_t got);
    out_item_t exp;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: byte %h valid %b ovf %b last %b",
                 got.out_byte, got.byte_valid, got.overflow, got.last);
      return;
    end
    exp = pending.pop_front();
    if (got.out_byte !== exp.out_byte || got.byte_valid !== exp.byte_valid ||
        got.overflow !== exp.overflow || got.last !== exp.last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp byte %h vld %b ovf %b last %b, got byte %h vld %b ovf %b last %b",
                 exp.out_byte, exp.byte_valid, exp.overflow, exp.last,
                 got.out_byte, got.byte_valid, got.overflow, got.last);
    end
  endfunction
endclass

module msb_first_bit_packer_unit_test;

  // Opcode 3 is not decoded by the block; name it for the no-op items.
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Let the block settle this long after its last result before a register write.
  localparam int unsigned SETTLE_CYCLES = 12;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_item_t         in_item_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_item_o;

  stream_scoreboard sb = new();

  int unsigned src_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned cycle_count  = 0;

  msb_first_bit_packer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result side at random; a zero percentage gives a clean stretch.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
  end

  // Check every result taken at this edge against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_byte(out_item_o);
  end

  // Bound the run so a hung handshake still ends with a verdict.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [1:0] op, int unsigned n, logic [63:0] v);
    in_item_t it;
    it.opcode = op;
    it.nbits  = NBITS_W'(n);
    it.value  = v;
    return it;
  endfunction

  // Present one item and hold it until accepted. Valid stays high afterwards so
  // back-to-back items never drop it; idle gaps lower it first.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
  endtask

  // Drain all expected results, let the block settle, then write the capacity.
  task automatic set_capacity(logic [CAP_W-1:0] cap);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.capacity = cap;
  endtask

  function automatic in_item_t random_item();
    int unsigned r;
    logic [1:0]  op;
    int unsigned n;
    logic [63:0] v;
    r = $urandom_range(99);
    if (r < 68)      op = OP_WRITE;
    else if (r < 82) op = OP_FLUSH;
    else if (r < 92) op = OP_RESTART;
    else             op = OP_UNUSED;
    r = $urandom_range(99);
    if (r < 60)      n = $urandom_range(16, 1);
    else if (r < 85) n = $urandom_range(64, 17);
    else if (r < 92) n = 64;
    else if (r < 96) n = 0;
    else             n = $urandom_range(127, 65);
    r = $urandom_range(99);
    if (r < 8)       v = '0;
    else if (r < 16) v = '1;
    else             v = {$urandom(), $urandom()};
    return make_item(op, n, v);
  endfunction

  // Send count random items; no-ops and zero-width writes are among them.
  task automatic run_random(int unsigned count);
    repeat (count) send_item(random_item());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender rarely idles, receiver mostly stalls.
    src_idle_pct = 14;
    rcv_idle_pct = 77;

    // Directed part at the reset capacity: fill, lazy emit, flushes, widths.
    send_item(make_item(OP_WRITE, 1, 64'h1));
    send_item(make_item(OP_WRITE, 7, 64'h55));           // stage full, held back
    send_item(make_item(OP_WRITE, 8, 64'hA5));           // releases the full stage
    send_item(make_item(OP_FLUSH, 0, 64'h0));            // flush of a full stage
    send_item(make_item(OP_FLUSH, 0, 64'h0));            // empty flush
    send_item(make_item(OP_WRITE, 64, '1));
    send_item(make_item(OP_WRITE, 64, 64'h0123456789ABCDEF)); // eight bytes out
    send_item(make_item(OP_WRITE, 0, '1));               // zero width
    send_item(make_item(OP_WRITE, 127, 64'hF0E1D2C3B4A59687)); // wide, saturates
    send_item(make_item(OP_WRITE, 65, 64'h8000000000000001));
    send_item(make_item(OP_WRITE, 3, 64'h1D));           // only the low bits count
    send_item(make_item(OP_FLUSH, 0, 64'h0));            // padded partial flush
    send_item(make_item(OP_UNUSED, 127, '1));
    send_item(make_item(OP_WRITE, 13, 64'h0));
    send_item(make_item(OP_WRITE, 5, 64'h1F));
    send_item(make_item(OP_RESTART, 0, 64'h0));          // restart with bits staged

    // Tiny destination: overflow on write, on flush, and restart clearing it.
    set_capacity(CAP_W'(3));
    send_item(make_item(OP_WRITE, 16, 64'hBEEF));
    send_item(make_item(OP_WRITE, 8, 64'h12));
    send_item(make_item(OP_WRITE, 4, 64'hF));            // room 1, write drops
    send_item(make_item(OP_FLUSH, 0, 64'h0));            // room 1, flush still fits
    send_item(make_item(OP_WRITE, 8, 64'h3C));
    send_item(make_item(OP_FLUSH, 0, 64'h0));            // no room left at all
    send_item(make_item(OP_RESTART, 0, 64'h0));

    // Zero capacity, then capacity one.
    set_capacity(CAP_W'(0));
    send_item(make_item(OP_WRITE, 9, 64'h1FF));
    send_item(make_item(OP_FLUSH, 0, 64'h0));
    set_capacity(CAP_W'(1));
    send_item(make_item(OP_RESTART, 0, 64'h0));
    send_item(make_item(OP_WRITE, 9, 64'h155));
    send_item(make_item(OP_FLUSH, 0, 64'h0));

    // Random part over several capacities; a capacity can be lowered mid-stream.
    set_capacity(CAP_W'(1048576));
    run_random(35);
    set_capacity(CAP_W'(12));
    run_random(35);

    // Sender mostly idles, receiver rarely stalls.
    src_idle_pct = 77;
    rcv_idle_pct = 14;
    set_capacity(CAP_RESET);
    run_random(35);
    set_capacity(CAP_W'(2));
    run_random(20);

    // No idling on either side.
    src_idle_pct = 0;
    rcv_idle_pct = 0;
    set_capacity(CAP_W'(0));
    run_random(12);
    set_capacity(CAP_W'(30));
    run_random(35);
    set_capacity(CAP_W'(1048575));
    run_random(30);

    // Drain and give stray results a chance to show up.
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (sb.pending.size() != 0) begin
      $display("%0d expected results never arrived", sb.pending.size());
      sb.errors += sb.pending.size();
    end
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
